// ===== rtl/ultlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultlc_pkg: shared constants and calendar helpers
// Day counts of the civil-from-days method, month codes, the zone offset
// limit and small month and leap-year lookups.
// ----------------------------------------------------------------------------
package ultlc_pkg;

  // Day count shift from 1970-01-01 to 0000-03-01
  localparam int EpochShiftDays = 719468;
  localparam int EraDays        = 146097;   // 400 Gregorian years
  localparam int Cycle4Days     = 1460;     // four years less the leap day
  localparam int CentDays       = 36524;
  localparam int EraLastDay     = 146096;
  localparam int YearDays       = 365;
  localparam int EraYears       = 400;
  localparam int DayMinutes     = 1440;
  localparam int HourMinutes    = 60;
  localparam int MinuteSeconds  = 60;
  localparam int DayHours       = 24;

  localparam logic signed [11:0] ZoneLimitPos = 12'sd1439;
  localparam logic signed [11:0] ZoneLimitNeg = -12'sd1439;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  // Gregorian leap rule; the century exceptions cover every year from 1801 to 2399
  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100) &&
           (y != 12'd2200) && (y != 12'd2300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the March-based year before the start of month index mp
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ultlc_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultlc_cdiv: two-stage divider by a constant
// Stage one multiplies by the truncated reciprocal, which gives the quotient
// or one less; stage two forms the remainder and corrects. A sideband word
// travels alongside. Valid/ready on both sides.
// ----------------------------------------------------------------------------
module ultlc_cdiv #(
  parameter int W  = 32,
  parameter int D  = 60,
  parameter int SW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [W-1:0]           x_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [W-1:0]           q_o,
  output logic [$clog2(D)-1:0]   r_o,
  output logic [SW-1:0]          side_o
);

  localparam int RW = $clog2(D);
  localparam logic [W-1:0] Recip = W'((64'd1 << W) / D);
  localparam logic [W-1:0] Div   = W'(D);

  logic [2*W-1:0] prod;
  logic           va_q;
  logic [W-1:0]   a_x_q, a_q_q;
  logic [SW-1:0]  a_side_q;
  logic           rdy_b;
  logic [W-1:0]   rem;
  logic           fix;
  logic [W-1:0]   q_d;
  logic [RW-1:0]  r_d;
  logic           vb_q;
  logic [W-1:0]   b_q_q;
  logic [RW-1:0]  b_r_q;
  logic [SW-1:0]  b_side_q;

  assign prod    = {{W{1'b0}}, x_i} * {{W{1'b0}}, Recip};
  assign rdy_b   = !vb_q || ready_i;
  assign ready_o = !va_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_o) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_x_q    <= x_i;
      a_q_q    <= prod[2*W-1:W];
      a_side_q <= side_i;
    end
  end

  // Estimate is low by at most one: the remainder stays below twice the divisor
  assign rem = a_x_q - a_q_q * Div;
  assign fix = (rem >= Div);
  assign q_d = a_q_q + W'(fix);
  assign r_d = fix ? RW'(rem - Div) : RW'(rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      b_q_q    <= q_d;
      b_r_q    <= r_d;
      b_side_q <= a_side_q;
    end
  end

  assign valid_o = vb_q;
  assign q_o     = b_q_q;
  assign r_o     = b_r_q;
  assign side_o  = b_side_q;

endmodule

// ===== rtl/unix_time_to_local_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_time_to_local_calendar: Unix seconds to local Gregorian date and time
// Pipelined conversion of a 32-bit seconds count into year, month, day,
// hour, minute and second, shifted by a programmable zone offset.
// ----------------------------------------------------------------------------
// The block takes one timestamp per clock while the output side does not stall
// and returns one calendar result per timestamp, in the order of the input
// transfers. The pipeline is a chain of valid/ready register stages: each
// stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds every item in place. Seconds, minutes,
// hours and days are split off by three constant dividers; the day count then
// goes through the 400-year era and day-of-era steps to a UTC date. The zone
// offset (minutes, two's complement, saturated to +/-1439 at write) is added
// to the minute of day and any whole-day carry or borrow rolls day, month and
// year with the full Gregorian leap rule. Seconds are never shifted. Write the
// offset only while the pipeline is empty.
// ----------------------------------------------------------------------------
module unix_time_to_local_calendar (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [11:0] zone_offset_minutes_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [11:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o
);

  // Zone offset register
  logic signed [11:0] off_q;
  logic signed [11:0] off_d;

  // Divider chain signals
  logic        v_a, rdy_a;
  logic [31:0] q_a;
  logic [5:0]  r_a;
  logic        v_b, rdy_b;
  logic [26:0] q_b;
  logic [5:0]  r_b, side_b;
  logic        v_c, rdy_c;
  logic [20:0] q_c;
  logic [4:0]  r_c;
  logic [11:0] side_c;
  logic [19:0] z;
  logic        v_e, rdy_e;
  logic [19:0] q_e;
  logic [17:0] r_e;
  logic [16:0] side_e;
  logic        v_f;
  logic [17:0] q_f;
  logic [37:0] side_f;
  logic [17:0] doe_f;

  // Year-of-era numerator stage
  logic        rdy_y;
  logic        v_y_q;
  logic [2:0]  n_cent;
  logic [17:0] y_num_d;
  logic [17:0] y_num_q;
  logic [37:0] y_side_q;

  // Day-of-year stage
  logic        v_g, rdy_g;
  logic [17:0] q_g;
  logic [37:0] side_g;
  logic [8:0]  yoe_g;
  logic [17:0] doe_g;
  logic [1:0]  c100;
  logic [17:0] yday_sub;
  logic [8:0]  doy_d;
  logic        rdy_dd;
  logic        v_d_q;
  logic [8:0]  d_doy_q, d_yoe_q;
  logic [2:0]  d_era_q;
  logic [16:0] d_tm_q;

  // Month index divider and civil date stage
  logic        v_h, rdy_h;
  logic [10:0] q_h;
  logic [37:0] side_h;
  logic [3:0]  mp;
  logic [8:0]  doy_h, yoe_h;
  logic [2:0]  era_h;
  logic        rdy_cc;
  logic        v_cc_q;
  logic [4:0]  day_d;
  logic [3:0]  month_d;
  logic [11:0] year_d;
  logic [11:0] c_year_q;
  logic [3:0]  c_month_q;
  logic [4:0]  c_day_q;
  logic        c_leap_q;
  logic [16:0] c_tm_q;

  // Offset stages
  logic               rdy_f1;
  logic               v_f1_q;
  logic [10:0]        tod_utc;
  logic signed [12:0] mod_d;
  logic               borrow_d, carry_d;
  logic [11:0]        f1_year_q;
  logic [3:0]         f1_month_q;
  logic [4:0]         f1_day_q;
  logic               f1_leap_q;
  logic [5:0]         f1_sec_q;
  logic signed [12:0] f1_mod_q;
  logic               f1_borrow_q, f1_carry_q;
  logic               rdy_f2;
  logic               v_f2_q;
  logic [11:0]        f2_year_d;
  logic [3:0]         f2_month_d;
  logic [4:0]         f2_day_d;
  logic [10:0]        f2_tod_d;
  logic [11:0]        f2_year_q;
  logic [3:0]         f2_month_q;
  logic [4:0]         f2_day_q;
  logic [5:0]         f2_sec_q;
  logic [10:0]        f2_tod_q;
  logic               rdy_o;
  logic [10:0]        q_o;
  logic [26:0]        side_o;

  // --------------------------------------------------------------------------
  // Zone offset: saturate on write so the shift never exceeds one day
  // --------------------------------------------------------------------------
  always_comb begin
    if (zone_offset_minutes_i > ultlc_pkg::ZoneLimitPos) begin
      off_d = ultlc_pkg::ZoneLimitPos;
    end else if (zone_offset_minutes_i < ultlc_pkg::ZoneLimitNeg) begin
      off_d = ultlc_pkg::ZoneLimitNeg;
    end else begin
      off_d = zone_offset_minutes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_we_i) begin
      off_q <= off_d;
    end
  end

  // --------------------------------------------------------------------------
  // Split off seconds, minutes and hours
  // --------------------------------------------------------------------------
  ultlc_cdiv #(.W(32), .D(ultlc_pkg::MinuteSeconds), .SW(1)) u_div_sec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (epoch_seconds_i),
    .side_i  (1'b0),
    .valid_o (v_a),
    .ready_i (rdy_a),
    .q_o     (q_a),
    .r_o     (r_a),
    .side_o  ()
  );

  ultlc_cdiv #(.W(27), .D(ultlc_pkg::HourMinutes), .SW(6)) u_div_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_a),
    .ready_o (rdy_a),
    .x_i     (q_a[26:0]),
    .side_i  (r_a),
    .valid_o (v_b),
    .ready_i (rdy_b),
    .q_o     (q_b),
    .r_o     (r_b),
    .side_o  (side_b)
  );

  ultlc_cdiv #(.W(21), .D(ultlc_pkg::DayHours), .SW(12)) u_div_hour (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_b),
    .ready_o (rdy_b),
    .x_i     (q_b[20:0]),
    .side_i  ({r_b, side_b}),
    .valid_o (v_c),
    .ready_i (rdy_c),
    .q_o     (q_c),
    .r_o     (r_c),
    .side_o  (side_c)
  );

  // --------------------------------------------------------------------------
  // Era and day of era: remainder of the era division is the day of era
  // --------------------------------------------------------------------------
  assign z = {4'b0000, q_c[15:0]} + 20'(ultlc_pkg::EpochShiftDays);

  ultlc_cdiv #(.W(20), .D(ultlc_pkg::EraDays), .SW(17)) u_div_era (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_c),
    .ready_o (rdy_c),
    .x_i     (z),
    .side_i  ({r_c, side_c}),
    .valid_o (v_e),
    .ready_i (rdy_e),
    .q_o     (q_e),
    .r_o     (r_e),
    .side_o  (side_e)
  );

  // Sideband from here on: {era[2:0], doe[17:0], hour, minute, second}
  ultlc_cdiv #(.W(18), .D(ultlc_pkg::Cycle4Days), .SW(38)) u_div_cyc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_e),
    .ready_o (rdy_e),
    .x_i     (r_e),
    .side_i  ({q_e[2:0], r_e, side_e}),
    .valid_o (v_f),
    .ready_i (rdy_y),
    .q_o     (q_f),
    .r_o     (),
    .side_o  (side_f)
  );

  // --------------------------------------------------------------------------
  // Year-of-era numerator: doe - doe/1460 + doe/36524 - doe/146096
  // Century and last-day quotients are small, so count them by compare
  // --------------------------------------------------------------------------
  assign doe_f  = side_f[34:17];
  assign n_cent = 3'(doe_f >= 18'(ultlc_pkg::CentDays)) +
                  3'(doe_f >= 18'(2 * ultlc_pkg::CentDays)) +
                  3'(doe_f >= 18'(3 * ultlc_pkg::CentDays)) +
                  3'(doe_f >= 18'(4 * ultlc_pkg::CentDays));
  assign y_num_d = doe_f - {11'b0, q_f[6:0]} + {15'b0, n_cent} -
                   18'(doe_f == 18'(ultlc_pkg::EraLastDay));
  assign rdy_y  = !v_y_q || rdy_g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_y_q <= 1'b0;
    end else if (rdy_y) begin
      v_y_q <= v_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_y && v_f) begin
      y_num_q  <= y_num_d;
      y_side_q <= side_f;
    end
  end

  ultlc_cdiv #(.W(18), .D(ultlc_pkg::YearDays), .SW(38)) u_div_yoe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_y_q),
    .ready_o (rdy_g),
    .x_i     (y_num_q),
    .side_i  (y_side_q),
    .valid_o (v_g),
    .ready_i (rdy_dd),
    .q_o     (q_g),
    .r_o     (),
    .side_o  (side_g)
  );

  // --------------------------------------------------------------------------
  // Day of year: doe - (365*yoe + yoe/4 - yoe/100)
  // --------------------------------------------------------------------------
  assign yoe_g    = q_g[8:0];
  assign doe_g    = side_g[34:17];
  assign c100     = 2'(yoe_g >= 9'd100) + 2'(yoe_g >= 9'd200) + 2'(yoe_g >= 9'd300);
  assign yday_sub = {9'b0, yoe_g} * 18'(ultlc_pkg::YearDays) + {11'b0, yoe_g[8:2]} -
                    {16'b0, c100};
  assign doy_d    = 9'(doe_g - yday_sub);
  assign rdy_dd   = !v_d_q || rdy_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
    end else if (rdy_dd) begin
      v_d_q <= v_g;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_dd && v_g) begin
      d_doy_q <= doy_d;
      d_yoe_q <= yoe_g;
      d_era_q <= side_g[37:35];
      d_tm_q  <= side_g[16:0];
    end
  end

  // Month index mp = (5*doy + 2) / 153
  ultlc_cdiv #(.W(11), .D(153), .SW(38)) u_div_mp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_d_q),
    .ready_o (rdy_h),
    .x_i     ({2'b00, d_doy_q} * 11'd5 + 11'd2),
    .side_i  ({d_doy_q, d_yoe_q, d_era_q, d_tm_q}),
    .valid_o (v_h),
    .ready_i (rdy_cc),
    .q_o     (q_h),
    .r_o     (),
    .side_o  (side_h)
  );

  // --------------------------------------------------------------------------
  // UTC civil date; March-based month index back to January-based month
  // --------------------------------------------------------------------------
  assign mp     = q_h[3:0];
  assign doy_h  = side_h[37:29];
  assign yoe_h  = side_h[28:20];
  assign era_h  = side_h[19:17];
  assign day_d  = 5'(doy_h - ultlc_pkg::days_before(mp) + 9'd1);
  assign month_d = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
  assign year_d = {3'b000, yoe_h} + {9'b0, era_h} * 12'(ultlc_pkg::EraYears) +
                  12'(month_d <= ultlc_pkg::MonthFeb);
  assign rdy_cc = !v_cc_q || rdy_f1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_cc_q <= 1'b0;
    end else if (rdy_cc) begin
      v_cc_q <= v_h;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_cc && v_h) begin
      c_year_q  <= year_d;
      c_month_q <= month_d;
      c_day_q   <= day_d;
      c_leap_q  <= ultlc_pkg::leap_year(year_d);
      c_tm_q    <= side_h[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // Offset, first half: minute of day plus offset, classify the day move
  // --------------------------------------------------------------------------
  assign tod_utc  = {6'b0, c_tm_q[16:12]} * 11'(ultlc_pkg::HourMinutes) +
                    {5'b0, c_tm_q[11:6]};
  assign mod_d    = $signed({2'b00, tod_utc}) + $signed({off_q[11], off_q});
  assign borrow_d = mod_d[12];
  assign carry_d  = !mod_d[12] && (mod_d >= 13'(ultlc_pkg::DayMinutes));
  assign rdy_f1   = !v_f1_q || rdy_f2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f1_q <= 1'b0;
    end else if (rdy_f1) begin
      v_f1_q <= v_cc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f1 && v_cc_q) begin
      f1_year_q   <= c_year_q;
      f1_month_q  <= c_month_q;
      f1_day_q    <= c_day_q;
      f1_leap_q   <= c_leap_q;
      f1_sec_q    <= c_tm_q[5:0];
      f1_mod_q    <= mod_d;
      f1_borrow_q <= borrow_d;
      f1_carry_q  <= carry_d;
    end
  end

  // --------------------------------------------------------------------------
  // Offset, second half: roll day, month and year over midnight.
  // Going back from the first of March lands on February of the same year,
  // so the stored leap flag serves both directions.
  // --------------------------------------------------------------------------
  always_comb begin
    f2_year_d  = f1_year_q;
    f2_month_d = f1_month_q;
    f2_day_d   = f1_day_q;
    f2_tod_d   = f1_mod_q[10:0];
    if (f1_borrow_q) begin
      f2_tod_d = 11'(f1_mod_q + 13'(ultlc_pkg::DayMinutes));
      if (f1_day_q == 5'd1) begin
        if (f1_month_q == ultlc_pkg::MonthJan) begin
          f2_month_d = ultlc_pkg::MonthDec;
          f2_year_d  = f1_year_q - 12'd1;
        end else begin
          f2_month_d = f1_month_q - 4'd1;
        end
        f2_day_d = ultlc_pkg::month_len(f2_month_d, f1_leap_q);
      end else begin
        f2_day_d = f1_day_q - 5'd1;
      end
    end else if (f1_carry_q) begin
      f2_tod_d = 11'(f1_mod_q - 13'(ultlc_pkg::DayMinutes));
      if (f1_day_q == ultlc_pkg::month_len(f1_month_q, f1_leap_q)) begin
        f2_day_d = 5'd1;
        if (f1_month_q == ultlc_pkg::MonthDec) begin
          f2_month_d = ultlc_pkg::MonthJan;
          f2_year_d  = f1_year_q + 12'd1;
        end else begin
          f2_month_d = f1_month_q + 4'd1;
        end
      end else begin
        f2_day_d = f1_day_q + 5'd1;
      end
    end
  end

  assign rdy_f2 = !v_f2_q || rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f2_q <= 1'b0;
    end else if (rdy_f2) begin
      v_f2_q <= v_f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f2 && v_f1_q) begin
      f2_year_q  <= f2_year_d;
      f2_month_q <= f2_month_d;
      f2_day_q   <= f2_day_d;
      f2_sec_q   <= f1_sec_q;
      f2_tod_q   <= f2_tod_d;
    end
  end

  // Local hour and minute; the last divider stage is the output register
  ultlc_cdiv #(.W(11), .D(ultlc_pkg::HourMinutes), .SW(27)) u_div_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_f2_q),
    .ready_o (rdy_o),
    .x_i     (f2_tod_q),
    .side_i  ({f2_year_q, f2_month_q, f2_day_q, f2_sec_q}),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .q_o     (q_o),
    .r_o     (minute_o),
    .side_o  (side_o)
  );

  assign hour_o   = q_o[4:0];
  assign year_o   = side_o[26:15];
  assign month_o  = side_o[14:11];
  assign day_o    = side_o[10:6];
  assign second_o = side_o[5:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_off_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_q <= ultlc_pkg::ZoneLimitPos) && (off_q >= ultlc_pkg::ZoneLimitNeg))
    else $error("zone offset register outside saturation range");

  a_zero_off_no_roll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_f1_q && (off_q == 12'sd0) |-> !f1_borrow_q && !f1_carry_q)
    else $error("day rolled with zero offset");

  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("time of day out of range");

  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= ultlc_pkg::MonthJan) && (month_o <= ultlc_pkg::MonthDec))
    else $error("month out of range");

  a_day_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (day_o >= 5'd1) &&
      (day_o <= ultlc_pkg::month_len(month_o, ultlc_pkg::leap_year(year_o))))
    else $error("day beyond month length");

endmodule

// ===== test/unix_time_to_local_calendar_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_time_to_local_calendar_tb: self-checking bench for the calendar block
// Drives Unix timestamps through the valid/ready input and checks each result
// against one typed in or predicted in the bench. A directed table covers the
// range ends, zone saturation and day, month and year roll-over in both
// directions. Random phases follow, each under its own zone offset and idle pattern.
// ----------------------------------------------------------------------------
module unix_time_to_local_calendar_tb;

  // One calendar result, laid out as the output ports
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // One directed stimulus row; the result is typed in only where known is set
  typedef struct packed {
    logic signed [11:0] zone;
    logic [31:0]        stamp;
    logic               known;
    cal_t               cal;
  } stamp_row_t;

  localparam int ZoneMax      = 1439;
  localparam int DayMins      = 1440;
  localparam int ShiftDays    = 719468;   // 1970-01-01 back to 0000-03-01
  localparam int EraLen       = 146097;   // days in 400 Gregorian years
  localparam int DirRows      = 23;
  localparam int Phases       = 12;
  localparam int PhaseItems   = 155;
  localparam int ListedZones  = 7;
  localparam int LongHold     = 160;      // far deeper than the pipeline
  localparam int DrainCycles  = 30;       // pipeline latency plus margin
  localparam int RunLimitNs   = 4_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic signed [11:0] zone_offset_minutes_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        epoch_seconds_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [11:0]        year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_o;
  logic [4:0]         hour_o;
  logic [5:0]         minute_o;
  logic [5:0]         second_o;

  // Bench copy of the zone register, as last written
  logic signed [11:0] zone_now = '0;
  // Typed-in result that travels with the timestamp on offer
  logic               stamp_known = 1'b0;
  cal_t               stamp_cal = '0;

  cal_t pending_calendars[$];
  int   accepted_stamps = 0;
  int   mismatches = 0;

  // Idle control: percentages per phase, and a request count for long holds
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  localparam logic signed [11:0] PhaseZones [ListedZones] = '{
    12'sd0, -12'sd1439, 12'sh7FF, 12'sh800, 12'sd1439, 12'sd60, -12'sd1
  };

  stamp_row_t directed_rows [DirRows] = '{
    // UTC from reset: range ends, end of day, leap day, end of February 2100
    '{12'sd0,     32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{12'sd0,     32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}},
    '{12'sd0,     32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{12'sd0,     32'd951782400,  1'b1, '{12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
    '{12'sd0,     32'd4107542399, 1'b1, '{12'd2100, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59}},
    // One minute back over midnight: year, leap and non-leap February, April
    '{-12'sd1,    32'd0,          1'b1, '{12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd0}},
    '{-12'sd1,    32'd951868800,  1'b1, '{12'd2000, 4'd2,  5'd29, 5'd23, 6'd59, 6'd0}},
    '{-12'sd1,    32'd4107542400, 1'b1, '{12'd2100, 4'd2,  5'd28, 5'd23, 6'd59, 6'd0}},
    '{-12'sd1,    32'd1709251200, 1'b1, '{12'd2024, 4'd2,  5'd29, 5'd23, 6'd59, 6'd0}},
    '{-12'sd1,    32'd1714521600, 1'b1, '{12'd2024, 4'd4,  5'd30, 5'd23, 6'd59, 6'd0}},
    // One minute forward over midnight: day, year, 2100 with no leap day
    '{12'sd1,     32'd86340,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
    '{12'sd1,     32'd4102444740, 1'b1, '{12'd2100, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{12'sd1,     32'd4107542340, 1'b1, '{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{12'sd1,     32'd951868740,  1'b1, '{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{12'sd1,     32'd1714521540, 1'b1, '{12'd2024, 4'd5,  5'd1,  5'd0,  6'd0,  6'd0}},
    // Register extremes saturate to a shift of just under one day
    '{12'sh7FF,   32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd8,  5'd6,  6'd27, 6'd15}},
    '{12'sh7FF,   32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd0}},
    '{12'sh800,   32'd0,          1'b1, '{12'd1969, 4'd12, 5'd31, 5'd0,  6'd1,  6'd0}},
    '{12'sh800,   32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd6,  5'd6,  6'd29, 6'd15}},
    '{12'sd1439,  32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd23, 6'd58, 6'd59}},
    '{-12'sd1439, 32'd59,         1'b1, '{12'd1969, 4'd12, 5'd31, 5'd0,  6'd1,  6'd59}},
    // Ordinary zones, left to the predictor
    '{12'sd330,   32'd1234567890, 1'b0, '0},
    '{-12'sd480,  32'd1700000000, 1'b0, '0}
  };

  unix_time_to_local_calendar u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .zone_offset_minutes_i (zone_offset_minutes_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .epoch_seconds_i       (epoch_seconds_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_o                 (day_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o)
  );

  // 12 ns clock, starting low
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Length of a month under the full Gregorian leap rule
  function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
    logic leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mon)
      ultlc_pkg::MonthApr, ultlc_pkg::MonthJun,
      ultlc_pkg::MonthSep, ultlc_pkg::MonthNov: return 30;
      ultlc_pkg::MonthFeb: return leap ? 29 : 28;
      default:  return 31;
    endcase
  endfunction

  // Expected local date and time for one timestamp under a raw zone value
  function automatic cal_t local_calendar(input logic [31:0] stamp,
                                          input logic signed [11:0] zone);
    int unsigned t, secs, mins, hrs, z, era, doe, yoe, doy, mp, yr, mon, dom;
    int          off, mod;
    cal_t        c;
    t    = stamp;
    secs = t % 60;  t = t / 60;
    mins = t % 60;  t = t / 60;
    hrs  = t % 24;  t = t / 24;
    // Days to a March-based year inside a 400-year era
    z    = t + ShiftDays;
    era  = z / EraLen;
    doe  = z - era * EraLen;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (yoe * 365 + yoe / 4 - yoe / 100);
    mp   = (doy * 5 + 2) / 153;
    dom  = doy - (mp * 153 + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    // Clamp the zone, then carry or borrow a whole day
    off = zone;
    if (off > ZoneMax) off = ZoneMax;
    if (off < -ZoneMax) off = -ZoneMax;
    mod = int'(hrs * 60 + mins) + off;
    if (mod < 0) begin
      mod = mod + DayMins;
      dom = dom - 1;
      if (dom == 0) begin
        if (mon == ultlc_pkg::MonthJan) begin
          mon = ultlc_pkg::MonthDec;
          yr  = yr - 1;
        end else begin
          mon = mon - 1;
        end
        dom = month_days(mon, yr);
      end
    end else if (mod >= DayMins) begin
      mod = mod - DayMins;
      dom = dom + 1;
      if (dom > month_days(mon, yr)) begin
        dom = 1;
        if (mon == ultlc_pkg::MonthDec) begin
          mon = ultlc_pkg::MonthJan;
          yr  = yr + 1;
        end else begin
          mon = mon + 1;
        end
      end
    end
    c.year   = yr[11:0];
    c.month  = mon[3:0];
    c.day    = dom[4:0];
    c.hour   = 5'(mod / 60);
    c.minute = 6'(mod % 60);
    c.second = secs[5:0];
    return c;
  endfunction

  // Day number, from 1970-01-01, of the first day of a month
  function automatic longint month_start_day(input int y, input int m);
    int yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * EraLen + doe - ShiftDays;
  endfunction

  // Random timestamp: plain 32-bit noise, both ends of the range, and a
  // large share within a day of a month start so that roll-over is common
  function automatic logic [31:0] random_stamp();
    int unsigned pick;
    int          y, m;
    longint      s;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom();
    if (pick < 48) return $urandom_range(200000);
    if (pick < 56) return 32'hFFFF_FFFF - $urandom_range(200000);
    // Lean on the century years and on March 1st, the end of February
    y = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 2000 : 2100)
                                 : $urandom_range(2106, 1970);
    m = ($urandom_range(2) == 0) ? 3 : $urandom_range(12, 1);
    s = month_start_day(y, m) * 86400 + longint'($urandom_range(172799)) - 86400;
    if (s < 0 || s > 64'hFFFF_FFFF) return $urandom();
    return s[31:0];
  endfunction

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offer one timestamp and hold it until the transfer; an optional gap
  // of idle cycles goes first
  task automatic send_stamp(input logic [31:0] stamp, input logic known, input cal_t cal);
    int seen;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      = 1'b1;
    epoch_seconds_i = stamp;
    stamp_known     = known;
    stamp_cal       = cal;
    seen            = accepted_stamps;
    do @(negedge clk_i); while (accepted_stamps == seen);
  endtask

  // Drain the pipeline, then write the zone register for one cycle
  task automatic apply_zone(input logic signed [11:0] zone);
    in_valid_i = 1'b0;
    while (pending_calendars.size() != 0) @(negedge clk_i);
    cfg_we_i              = 1'b1;
    zone_offset_minutes_i = zone;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    zone_now = zone;
  endtask

  // Receiver: random stalls, and a long hold-off counted here whenever the
  // main sequence asks for one
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  // Record each input transfer with its expected calendar, then check each
  // output transfer against the oldest one waiting
  always @(posedge clk_i) begin : transfer_monitor
    cal_t want;
    cal_t got;
    if (in_valid_i && in_ready_o) begin
      pending_calendars.push_back(stamp_known ? stamp_cal
                                              : local_calendar(epoch_seconds_i, zone_now));
      accepted_stamps <= accepted_stamps + 1;
    end
    if (out_valid_o && out_ready_i) begin
      got = {year_o, month_o, day_o, hour_o, minute_o, second_o};
      if (pending_calendars.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                 $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
      end else begin
        want = pending_calendars.pop_front();
        compare_field("year",   want.year,   got.year);
        compare_field("month",  want.month,  got.month);
        compare_field("day",    want.day,    got.day);
        compare_field("hour",   want.hour,   got.hour);
        compare_field("minute", want.minute, got.minute);
        compare_field("second", want.second, got.second);
      end
    end
  end

  initial begin : stimulus
    int                 p, i, r;
    int unsigned        raw;
    logic signed [11:0] zone;
    // Hold reset, then release it away from the rising edge
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table; the first rows run on the zone left by reset
    for (r = 0; r < DirRows; r++) begin
      if (directed_rows[r].zone != zone_now) apply_zone(directed_rows[r].zone);
      send_stamp(directed_rows[r].stamp, directed_rows[r].known, directed_rows[r].cal);
    end

    // Random phases: listed zones first (extremes included), then raw
    // 12-bit values; the idle pattern turns over every phase
    for (p = 0; p < Phases; p++) begin
      if (p < ListedZones) begin
        zone = PhaseZones[p];
      end else begin
        raw  = $urandom_range(4095);
        zone = raw[11:0];
      end
      apply_zone(zone);
      case (p % 4)
        0: begin
          // Steady sender against a receiver that holds off for a long
          // stretch, so that the pipeline fills and stalls its input
          send_idle_pct = 0;
          stall_pct    <= 0;
          hold_req     <= hold_req + 1;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 86;
        end
        default: begin
          send_idle_pct = 6;
          stall_pct    <= 6;
        end
      endcase
      for (i = 0; i < PhaseItems; i++) send_stamp(random_stamp(), 1'b0, '0);
    end

    // Drop valid, let every result out, then allow stragglers to show up
    in_valid_i    = 1'b0;
    send_idle_pct = 0;
    stall_pct    <= 0;
    while (pending_calendars.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** unix_time_to_local_calendar: PASSED **");
    end else begin
      $display("** unix_time_to_local_calendar: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #(RunLimitNs);
    $display("** unix_time_to_local_calendar: FAILED **");
    $finish;
  end

endmodule
